// ===== design/lkv_pkg.sv =====
// ----------------------------------------------------------------------------
// lkv_pkg: shared types and constants for the LRU key/value cache
// Request and response records, command codes and register defaults.
// ----------------------------------------------------------------------------
package lkv_pkg;

  localparam int KEY_W = 32;
  localparam int VAL_W = 32;
  localparam int CAP_W = 5;

  localparam logic CMD_GET = 1'b0;
  localparam logic CMD_PUT = 1'b1;

  localparam logic [CAP_W-1:0] CAP_RESET  = 5'd16;
  localparam logic [VAL_W-1:0] MISS_VALUE = '1;

  typedef struct packed {
    logic                    cmd;
    logic signed [KEY_W-1:0] key;
    logic signed [VAL_W-1:0] value;
  } req_t;

  typedef struct packed {
    logic                    hit;
    logic signed [VAL_W-1:0] read_value;
  } rsp_t;

endpackage

// ===== design/lkv_store.sv =====
// ----------------------------------------------------------------------------
// lkv_store: entry array with parallel key compare and recency ranks
// Resolves one request per cycle and commits the entry update on fire.
// ----------------------------------------------------------------------------
module lkv_store import lkv_pkg::*; #(
  parameter int MAX_ENTRIES = 16
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic [CAP_W-1:0] cap,
  input  req_t             req,
  input  logic             fire,
  output rsp_t             rsp
);

  localparam int RK_W  = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int CNT_W = $clog2(MAX_ENTRIES + 1);

  logic [KEY_W-1:0] key_r  [MAX_ENTRIES];
  logic [VAL_W-1:0] val_r  [MAX_ENTRIES];
  logic [RK_W-1:0]  rank_r [MAX_ENTRIES];
  logic [CNT_W-1:0] count_r, count_nxt;

  logic [MAX_ENTRIES-1:0] valid_vec, hit_vec, oldest_vec, free_vec, tgt_vec;
  logic [CNT_W-1:0]       count_m1;
  logic [CAP_W-1:0]       eff_cap;
  logic                   found, is_put, insert, touch, full;
  logic [RK_W-1:0]        hit_rank;
  logic [VAL_W-1:0]       hit_val;

  // Entries never leave, so the valid entries are always slots 0 .. count-1
  // and their ranks are a permutation of 0 .. count-1.
  assign count_m1 = count_r - CNT_W'(1);

  for (genvar i = 0; i < MAX_ENTRIES; i++) begin : g_cmp
    assign valid_vec[i]  = count_r > CNT_W'(i);
    assign hit_vec[i]    = valid_vec[i] && (key_r[i] == req.key);
    assign oldest_vec[i] = valid_vec[i] && (rank_r[i] == count_m1[RK_W-1:0]);
    assign free_vec[i]   = count_r == CNT_W'(i);
  end

  // At most one entry matches: combine rank and value by OR.
  always_comb begin
    hit_rank = '0;
    hit_val  = '0;
    for (int i = 0; i < MAX_ENTRIES; i++) begin
      hit_rank = hit_rank | (rank_r[i] & {RK_W{hit_vec[i]}});
      hit_val  = hit_val  | (val_r[i]  & {VAL_W{hit_vec[i]}});
    end
  end

  assign found   = |hit_vec;
  assign is_put  = req.cmd == CMD_PUT;
  assign eff_cap = (cap == '0) ? CAP_W'(1) : cap;
  assign full    = (count_r == CNT_W'(MAX_ENTRIES)) ||
                   ({{CAP_W{1'b0}}, count_r} >= {{CNT_W{1'b0}}, eff_cap});
  assign insert  = fire && is_put && !found;
  assign touch   = fire && found;
  assign tgt_vec = found ? hit_vec : (full ? oldest_vec : free_vec);

  always_comb begin
    count_nxt = count_r;
    if (insert && !full) begin
      count_nxt = count_r + CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else begin
      count_r <= count_nxt;
    end
  end

  for (genvar i = 0; i < MAX_ENTRIES; i++) begin : g_entry
    logic            age;
    logic [RK_W-1:0] rank_nxt;

    // Hit: age the newer entries. Insert: age every other valid entry.
    assign age = (touch && valid_vec[i] && !hit_vec[i] && (rank_r[i] < hit_rank)) ||
                 (insert && valid_vec[i] && !tgt_vec[i]);

    always_comb begin
      rank_nxt = rank_r[i];
      if ((touch || insert) && tgt_vec[i]) begin
        rank_nxt = '0;
      end else if (age) begin
        rank_nxt = rank_r[i] + RK_W'(1);
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        rank_r[i] <= '0;
      end else begin
        rank_r[i] <= rank_nxt;
      end
    end

    always_ff @(posedge clk) begin
      if (insert && tgt_vec[i]) begin
        key_r[i] <= req.key;
      end
      if (fire && is_put && tgt_vec[i]) begin
        val_r[i] <= req.value;
      end
    end
  end

  always_comb begin
    rsp.hit = found;
    if (is_put) begin
      rsp.read_value = '0;
    end else if (found) begin
      rsp.read_value = hit_val;
    end else begin
      rsp.read_value = MISS_VALUE;
    end
  end

endmodule

// ===== design/lru_key_value_cache.sv =====
// ----------------------------------------------------------------------------
// lru_key_value_cache: fully associative key/value cache, LRU replacement
// Input register, single-pass lookup/update, registered response.
// ----------------------------------------------------------------------------
// Usage:
//   in_*  : request stream. in_tuser is the command (0 get, 1 put),
//           in_tdata carries key and value.
//   out_* : one response per request, in order. out_tuser is the hit flag,
//           out_tdata the read value (stored value on get hit, -1 on get
//           miss, 0 for put).
//   cfg_* : capacity register, for the user to write only while the cache is idle; the block does not enforce it.
// out_tvalid rises once the accepted request has passed from the request
// register into the response register. One request is accepted per cycle
// while the response register can advance; the key compare against all
// entries and the rank update both complete combinationally between the
// request register and the response register.
// Reset empties the cache and sets capacity to 16. When the receiver stalls
// the response holds, one more request is held in the request register,
// and in_tready drops after that.
// ----------------------------------------------------------------------------
module lru_key_value_cache import lkv_pkg::*; #(
  parameter int MAX_ENTRIES = 16
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_tvalid,
  output logic             in_tready,
  input  logic [63:0]      in_tdata,   // [31:0] key, [63:32] value
  input  logic [0:0]       in_tuser,   // [0] cmd
  output logic             out_tvalid,
  input  logic             out_tready,
  output logic [31:0]      out_tdata,  // [31:0] read_value
  output logic [0:0]       out_tuser,  // [0] hit
  input  logic             cfg_we,
  input  logic [CAP_W-1:0] cfg_wdata
);

  logic             in_vld_r, in_vld_nxt;
  req_t             in_req_r;
  logic             out_vld_r, out_vld_nxt;
  rsp_t             out_rsp_r;
  rsp_t             rsp;
  logic [CAP_W-1:0] cap_r;
  logic             advance, in_fire;

  assign advance   = in_vld_r && (!out_vld_r || out_tready);
  assign in_tready = !in_vld_r || advance;
  assign in_fire   = in_tvalid && in_tready;

  always_comb begin
    in_vld_nxt = in_vld_r;
    if (in_fire) begin
      in_vld_nxt = 1'b1;
    end else if (advance) begin
      in_vld_nxt = 1'b0;
    end
    out_vld_nxt = out_vld_r;
    if (advance) begin
      out_vld_nxt = 1'b1;
    end else if (out_tready) begin
      out_vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
      cap_r     <= CAP_RESET;
    end else begin
      in_vld_r  <= in_vld_nxt;
      out_vld_r <= out_vld_nxt;
      if (cfg_we) begin
        cap_r <= cfg_wdata;
      end
    end
  end

  // Hold the request until the response stage is free.
  always_ff @(posedge clk) begin
    if (in_fire) begin
      in_req_r.cmd   <= in_tuser[0];
      in_req_r.key   <= in_tdata[31:0];
      in_req_r.value <= in_tdata[63:32];
    end
    if (advance) begin
      out_rsp_r <= rsp;
    end
  end

  lkv_store #(
    .MAX_ENTRIES (MAX_ENTRIES)
  ) u_store (
    .clk   (clk),
    .rst_n (rst_n),
    .cap   (cap_r),
    .req   (in_req_r),
    .fire  (advance),
    .rsp   (rsp)
  );

  assign out_tvalid = out_vld_r;
  assign out_tdata  = out_rsp_r.read_value;
  assign out_tuser  = out_rsp_r.hit;

endmodule
